### rtl/fir_rs_pkg.sv
`default_nettype none

package fir_rs_pkg;

   // Sample and coefficient formats.
   localparam int SAMPLE_W = 8;
   localparam int COEF_W = 8;
   localparam int PROD_W = SAMPLE_W + COEF_W;

   // Coefficient banks: eight signed bytes to a 64-bit register.
   localparam int BANK_W = 64;
   localparam int COEF_PER_BANK = BANK_W / COEF_W;
   localparam int NUM_BANKS = 4;

   // Accumulator holds 32 full-scale products without overflow.
   localparam int ACC_W = 21;

   // Rounding and shifting run on a wider word so that the rounding term
   // for any 5-bit shift fits.
   localparam int SHIFT_W = 5;
   localparam int ROUND_W = 32;
   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd7;

   // Saturation limits of the output sample.
   localparam logic signed [ROUND_W-1:0] SAT_HI = 32'sd127;
   localparam logic signed [ROUND_W-1:0] SAT_LO = -32'sd128;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEFF_BANK_0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEFF_BANK_1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEFF_BANK_2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEFF_BANK_3 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_SHIFT = 3'd4;

   // Partial sum and its marker, handed from one cell to the next.
   typedef struct packed {
      logic                    tok;
      logic signed [ACC_W-1:0] sum;
   } link_type;

endpackage

`default_nettype wire

### rtl/fir_rs_cell.sv
`default_nettype none

module fir_rs_cell
   import fir_rs_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       shift_en,
   input  wire logic signed [SAMPLE_W-1:0] smp_in,
   input  wire logic signed [COEF_W-1:0]   coef,
   input  wire link_type                   link_in,
   output logic signed [SAMPLE_W-1:0]      smp_out,
   output link_type                        link_out
);

   logic signed [SAMPLE_W-1:0] smp_ff;
   logic signed [PROD_W-1:0]   prod;
   logic signed [ACC_W-1:0]    sum_in;
   logic signed [ACC_W-1:0]    sum_ff;
   logic                       tok_ff;

   // The sample moves one cell down the chain with every accepted word.
   always_ff @(posedge clock) begin
      if (shift_en) begin
         smp_ff <= smp_in;
      end
   end

   // This tap's product is added to the partial sum as it passes.
   always_comb begin
      prod = coef * smp_ff;
      sum_in = link_in.sum + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
   end

   always_ff @(posedge clock) begin
      if (link_in.tok) begin
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= 1'b0;
      end else begin
         tok_ff <= link_in.tok;
      end
   end

   assign smp_out = smp_ff;
   assign link_out = '{tok: tok_ff, sum: sum_ff};

endmodule

`default_nettype wire

### rtl/fir_rs_scale.sv
`default_nettype none

module fir_rs_scale
   import fir_rs_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire link_type             link_in,
   input  wire logic [SHIFT_W-1:0]   shift,
   output logic                      res_valid,
   output logic [SAMPLE_W-1:0]       res_sample
);

   logic [ROUND_W-1:0]        term;
   logic signed [ROUND_W-1:0] rnd_in;
   logic signed [ROUND_W-1:0] rnd_ff;
   logic                      vld_ff;
   logic signed [ROUND_W-1:0] shifted;

   // Add half of the shift's weight so that the floor shift rounds to nearest.
   always_comb begin
      if (shift == '0) begin
         term = '0;
      end else begin
         term = ROUND_W'(1) << (shift - SHIFT_W'(1));
      end
      rnd_in = $signed({{(ROUND_W-ACC_W){link_in.sum[ACC_W-1]}}, link_in.sum} + term);
   end

   always_ff @(posedge clock) begin
      if (link_in.tok) begin
         rnd_ff <= rnd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= link_in.tok;
      end
   end

   // Arithmetic shift, then clamp to the 8-bit range.
   always_comb begin
      shifted = rnd_ff >>> shift;
      if (shifted > SAT_HI) begin
         res_sample = SAT_HI[SAMPLE_W-1:0];
      end else if (shifted < SAT_LO) begin
         res_sample = SAT_LO[SAMPLE_W-1:0];
      end else begin
         res_sample = shifted[SAMPLE_W-1:0];
      end
   end

   assign res_valid = vld_ff;

endmodule

`default_nettype wire

### rtl/fir_filter_int8_round_saturate_unit.sv
// FIR filter with signed 8-bit samples and coefficients, rounding, scaling
// and saturation to signed 8 bits.
//
// Input words arrive on req_valid / req_stall / req_sample_in, results leave
// on rsp_valid / rsp_stall / rsp_filtered_sample. A word moves at a clock
// edge with valid high and stall low. Coefficients and the shift go through
// csr_valid / csr_ready / csr_index / csr_data; the user must write them only
// while the filter is idle, and the block itself does not enforce it.
//
// Samples sit in a chain of TAPS cells. After a sample is taken, a partial
// sum walks down the chain one cell per cycle, each cell adding its
// coefficient times its sample. The result passes the cell registers, the
// rounding register and the output register; the next sample is taken only
// after the result leaves. The first TAPS - 1 samples after reset only fill
// the chain; they produce no result and are taken one per cycle.
//
// Reset clears the fill count, coefficients to zero and the shift to 7.
// While the receiver stalls, the result holds and req_stall stays high.
`default_nettype none

module fir_filter_int8_round_saturate_unit
   import fir_rs_pkg::*;
#(
   parameter int TAPS = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic signed [SAMPLE_W-1:0] req_sample_in,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0]      rsp_filtered_sample,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CSR_IDX_W-1:0]       csr_index,
   input  wire logic [BANK_W-1:0]          csr_data
);

   localparam int CNT_W = (TAPS > 1) ? $clog2(TAPS) : 1;

   logic [BANK_W-1:0]          coeff_bank_ff [NUM_BANKS];
   logic [SHIFT_W-1:0]         scale_shift_ff;
   logic [CNT_W-1:0]           fill_ff;
   logic [CNT_W-1:0]           fill_in;
   logic                       start_ff;
   logic                       busy_ff;
   logic                       busy_in;
   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff;
   logic                       req_accept;
   logic                       rsp_accept;
   logic                       emit;
   logic                       res_valid;
   logic [SAMPLE_W-1:0]        res_sample;

   link_type                   link [TAPS+1];
   logic signed [SAMPLE_W-1:0] smp  [TAPS+1];

   assign csr_ready = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < NUM_BANKS; b++) begin
            coeff_bank_ff[b] <= '0;
         end
         scale_shift_ff <= SHIFT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_COEFF_BANK_0: coeff_bank_ff[0] <= csr_data;
            CSR_COEFF_BANK_1: coeff_bank_ff[1] <= csr_data;
            CSR_COEFF_BANK_2: coeff_bank_ff[2] <= csr_data;
            CSR_COEFF_BANK_3: coeff_bank_ff[3] <= csr_data;
            CSR_SCALE_SHIFT:  scale_shift_ff <= csr_data[SHIFT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Handshakes and warm-up count.
   always_comb begin
      req_accept = req_valid && !req_stall;
      rsp_accept = rsp_valid_ff && !rsp_stall;
      emit = (fill_ff == CNT_W'(TAPS - 1));
      fill_in = fill_ff;
      if (req_accept && !emit) begin
         fill_in = fill_ff + CNT_W'(1);
      end
      busy_in = busy_ff;
      if (req_accept && emit) begin
         busy_in = 1'b1;
      end else if (rsp_accept) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         busy_ff <= 1'b0;
         start_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         busy_ff <= busy_in;
         start_ff <= req_accept && emit;
      end
   end

   assign req_stall = busy_ff;

   // Chain of tap cells; the partial sum enters at cell zero.
   assign link[0] = '{tok: start_ff, sum: '0};
   assign smp[0] = req_sample_in;

   for (genvar k = 0; k < TAPS; k++) begin : g_cell
      fir_rs_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (req_accept),
         .smp_in   (smp[k]),
         .coef     ($signed(coeff_bank_ff[k / COEF_PER_BANK]
                            [COEF_W*(k % COEF_PER_BANK) +: COEF_W])),
         .link_in  (link[k]),
         .smp_out  (smp[k+1]),
         .link_out (link[k+1])
      );
   end

   fir_rs_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .link_in    (link[TAPS]),
      .shift      (scale_shift_ff),
      .res_valid  (res_valid),
      .res_sample (res_sample)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_accept) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_sample_ff <= $signed(res_sample);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_filtered_sample = rsp_sample_ff;

endmodule

`default_nettype wire

### rtl/fir_rs_checker.sv
`default_nettype none

module fir_rs_checker
   import fir_rs_pkg::*;
(
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_stall,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_stall,
   input wire logic signed [SAMPLE_W-1:0] rsp_filtered_sample
);

   // A pending result keeps the input side closed.
   a_result_blocks_input: assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall
   ) else $error("input open while a result is pending");

   // A result only appears after a word was taken and the input closed.
   a_result_follows_busy: assert property (
      @(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall)
   ) else $error("result appeared without a word in flight");

   // A stalled result stays offered.
   a_valid_holds: assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid
   ) else $error("result withdrawn under stall");

   // A stalled result keeps its value.
   a_data_holds: assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_filtered_sample)
   ) else $error("result changed under stall");

endmodule

bind fir_filter_int8_round_saturate_unit fir_rs_checker u_fir_rs_checker (
   .clock               (clock),
   .reset               (reset),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_filtered_sample (rsp_filtered_sample)
);

`default_nettype wire
